// File: hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; positional_list_engine in hw/rtl and the testbench import this package, ple_ram does not.
`timescale 1ns / 1ps

package ple_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 6;
   localparam int CMD_W        = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE       = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] item_value;
      logic                     last;
      logic                     list_empty;
      logic                     overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT,
      ST_EMIT
   } state_type;

endpackage

// File: hw/rtl/positional_list_engine.sv
// An insert at the front shifts count entries one per cycle toward the back, a delete
// shifts count - position - 1 entries toward the front, and an append writes one entry;
// the listing then streams one word per cycle while the sink is ready. A new command is
// taken only in idle, once the listing of the last one is out; the shift and the listing
// both walk the single read port of the entry RAM. Synchronous reset empties the
// list; the RAM itself is not cleared, since entries beyond the count are never read.
`timescale 1ns / 1ps

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     ovf_ff, ovf_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            left_ff, left_in;
   logic                     wv_ff, wv_in;
   logic [IW-1:0]            wa_ff, wa_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en;
   logic [IW-1:0]            ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic                     ram_rd_en;
   logic [IW-1:0]            ram_rd_addr;
   logic [DATA_W-1:0]        ram_rd_data;

   logic                     accept;
   logic                     full;
   logic                     shift_up;
   logic                     out_free;
   logic [CW-1:0]            cnt_m1;
   logic [CMPW-1:0]          pos_ext;
   logic [CMPW-1:0]          cnt_ext;
   logic [CMPW-1:0]          pos_p1;
   logic [CMPW-1:0]          del_left;
   logic [CW-1:0]            idx_p1;

   ple_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept   = req_valid && req_ready;
   assign full     = (count_ff == CW'(CAPACITY));
   assign shift_up = (cmd_ff == CMD_INSERT_FRONT);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cnt_m1   = count_ff - CW'(1);
   assign pos_ext  = CMPW'(req_data.position);
   assign cnt_ext  = CMPW'(count_ff);
   assign pos_p1   = pos_ext + CMPW'(1);
   assign del_left = cnt_ext - pos_ext - CMPW'(1);
   assign idx_p1   = CW'(idx_ff) + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wv_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wv_ff        <= wv_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      ovf_ff      <= ovf_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      wa_ff       <= wa_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      wv_in        = 1'b0;
      wa_in        = wa_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_data.command;
               val_in  = req_data.value;
               ovf_in  = 1'b0;
               pend_in = 1'b0;
               idx_in  = '0;
               left_in = '0;
               state_in = ST_EMIT;
               if (full && (req_data.command inside {CMD_INSERT_FRONT, CMD_APPEND})) begin
                  ovf_in = 1'b1;
               end else begin
                  case (req_data.command)
                     CMD_INSERT_FRONT: begin
                        idx_in   = cnt_m1[IW-1:0];
                        left_in  = count_ff;
                        state_in = ST_SHIFT;
                     end
                     CMD_APPEND: begin
                        state_in = ST_PUT;
                     end
                     CMD_DELETE: begin
                        if (pos_ext < cnt_ext) begin
                           idx_in   = pos_p1[IW-1:0];
                           left_in  = del_left[CW-1:0];
                           state_in = ST_SHIFT;
                        end
                     end
                     default: begin
                        state_in = ST_EMIT;
                     end
                  endcase
               end
            end
         end

         ST_SHIFT: begin
            // Read one entry per cycle; the word read last cycle is written one slot
            // further toward the back (insert) or toward the front (delete).
            if (left_ff != '0) begin
               ram_rd_en = 1'b1;
               wv_in     = 1'b1;
               wa_in     = idx_ff;
               idx_in    = shift_up ? (idx_ff - IW'(1)) : (idx_ff + IW'(1));
               left_in   = left_ff - CW'(1);
            end
            if (wv_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = shift_up ? (wa_ff + IW'(1)) : (wa_ff - IW'(1));
            end
            if ((left_ff == '0) && !wv_ff) begin
               pend_in = 1'b0;
               idx_in  = '0;
               if (shift_up) begin
                  state_in = ST_PUT;
               end else begin
                  count_in = cnt_m1;
                  state_in = ST_EMIT;
               end
            end
         end

         ST_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = shift_up ? '0 : count_ff[IW-1:0];
            ram_wr_data = val_ff;
            count_in    = count_ff + CW'(1);
            pend_in     = 1'b0;
            idx_in      = '0;
            state_in    = ST_EMIT;
         end

         ST_EMIT: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.item_value = '0;
                  rsp_data_in.last       = 1'b1;
                  rsp_data_in.list_empty = 1'b1;
                  rsp_data_in.overflow   = ovf_ff;
                  state_in               = ST_IDLE;
               end
            end else if (!pend_ff) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
            end else if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.item_value = ram_rd_data;
               rsp_data_in.last       = (idx_p1 == count_ff);
               rsp_data_in.list_empty = 1'b0;
               rsp_data_in.overflow   = ovf_ff;
               if (idx_p1 == count_ff) begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  // Fetch the next word while this one is on its way out.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_p1[IW-1:0];
                  idx_in      = idx_p1[IW-1:0];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.list_empty) |-> rsp_data_ff.last)
      else $error("empty listing word without last marker");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) || (state_ff == ST_EMIT)) |-> !ram_wr_en)
      else $error("store written outside a shift or put");

   a_count_stable_shift: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && $past(state_ff == ST_SHIFT)) |-> $stable(count_ff))
      else $error("entry count changed in the middle of a shift");

   // A dropped insert leaves the count untouched for the whole listing.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && ovf_ff) |-> (count_ff == CW'(CAPACITY)))
      else $error("overflow flagged while the list has room");
`endif

endmodule

// File: hw/rtl/ple_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the list entry store of the positional list engine.
`timescale 1ns / 1ps

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for positional_list_engine: drives insert, append, delete and spare-code words
// and checks every listing word against a shadow copy of the list. Depends on ple_pkg.
`timescale 1ns / 1ps

module tb_top
   import ple_pkg::*;
();

   localparam int                LIST_CAP     = CAPACITY_DEF;
   localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [DATA_W-1:0] VAL_MIN      = 32'h8000_0000;
   localparam logic [DATA_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
   localparam int                DRAIN_CYCLES = 4 * LIST_CAP + 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow of the list and the listing words still owed by the block.
   logic signed [DATA_W-1:0] shadow_list [LIST_CAP];
   int unsigned              shadow_count = 0;
   rsp_type                  expected_words [$];

   int unsigned fail_count = 0;
   int unsigned sink_wait  = 0;
   bit          gap_on     = 1'b1;
   bit          stall_on   = 1'b1;

   positional_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAIL positional_list_engine");
      $finish;
   end

   function automatic void note_failure(string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endfunction

   // Applies one accepted command to the shadow list and queues the listing it causes.
   function automatic void apply_command(req_type c);
      rsp_type w;
      logic    dropped;
      int      i;
      dropped = 1'b0;
      case (c.command)
         CMD_INSERT_FRONT, CMD_APPEND: begin
            if (shadow_count >= LIST_CAP) begin
               dropped = 1'b1;
            end else if (c.command == CMD_INSERT_FRONT) begin
               for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
               shadow_list[0] = c.value;
               shadow_count++;
            end else begin
               shadow_list[shadow_count] = c.value;
               shadow_count++;
            end
         end
         CMD_DELETE: begin
            if (c.position < shadow_count) begin
               for (i = c.position; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
               shadow_count--;
            end
         end
         default: ;
      endcase
      if (shadow_count == 0) begin
         w.item_value = '0;
         w.last       = 1'b1;
         w.list_empty = 1'b1;
         w.overflow   = dropped;
         expected_words.push_back(w);
      end else begin
         for (i = 0; i < shadow_count; i++) begin
            w.item_value = shadow_list[i];
            w.last       = (i + 1 == shadow_count);
            w.list_empty = 1'b0;
            w.overflow   = dropped;
            expected_words.push_back(w);
         end
      end
   endfunction

   function automatic void check_word(rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         note_failure($sformatf("unexpected word value=%h last=%b empty=%b ovf=%b",
                                got.item_value, got.last, got.list_empty, got.overflow));
         return;
      end
      want = expected_words.pop_front();
      if (got.last !== want.last || got.list_empty !== want.list_empty ||
          got.overflow !== want.overflow || got.item_value !== want.item_value) begin
         note_failure($sformatf({"expected value=%h last=%b empty=%b ovf=%b, ",
                                 "got value=%h last=%b empty=%b ovf=%b"},
                                want.item_value, want.last, want.list_empty, want.overflow,
                                got.item_value, got.last, got.list_empty, got.overflow));
      end
   endfunction

   // Result sink: with stalls on, ready drops after each accepted word for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_word(rsp_data);
            sink_wait = stall_on ? $urandom_range(0, 8) : 0;
         end else if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
         end
         rsp_ready <= (sink_wait == 0);
      end
   end

   // Valid is only lowered when a gap follows, so it never toggles within one step.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos);
      req_type     c;
      int unsigned gap;
      gap = gap_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      c.command  = cmd;
      c.value    = val;
      c.position = pos;
      req_data  <= c;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(c);
   endtask

   task automatic wait_for_listing();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_edge_cases();
      gap_on   = 1'b1;
      stall_on = 1'b1;
      // Empty list: delete at the first and the highest position, then the spare code.
      send_command(CMD_DELETE, $urandom, 6'd0);
      send_command(CMD_DELETE, $urandom, 6'd63);
      send_command(CMD_UNUSED, $urandom, 6'd0);
      send_command(CMD_INSERT_FRONT, VAL_MAX, 6'd63);
      send_command(CMD_APPEND, VAL_MIN, 6'd0);
      send_command(CMD_INSERT_FRONT, '1, 6'd0);
      send_command(CMD_APPEND, '0, 6'd63);
      send_command(CMD_UNUSED, VAL_MAX, 6'd1);
      // Positions at and beyond the count are ignored; the deletes that follow empty the list.
      send_command(CMD_DELETE, '0, 6'd63);
      send_command(CMD_DELETE, '0, 6'd4);
      send_command(CMD_DELETE, '0, 6'd1);
      send_command(CMD_DELETE, '0, 6'd2);
      send_command(CMD_DELETE, '0, 6'd0);
      send_command(CMD_DELETE, '0, 6'd0);
      send_command(CMD_DELETE, '0, 6'd0);
      send_command(CMD_APPEND, 32'h0000_0001, 6'd0);
      send_command(CMD_DELETE, '0, 6'd0);
      wait_for_listing();
   endtask

   task automatic test_fill_and_overflow();
      gap_on   = 1'b0;
      stall_on = 1'b0;
      while (shadow_count < LIST_CAP) begin
         send_command($urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_FRONT, $urandom,
                      POS_W'($urandom_range(0, 63)));
      end
      gap_on   = 1'b1;
      stall_on = 1'b1;
      // Inserts into a full list are dropped and flagged.
      send_command(CMD_INSERT_FRONT, VAL_MIN, 6'd0);
      send_command(CMD_APPEND, VAL_MAX, 6'd0);
      send_command(CMD_UNUSED, $urandom, 6'd0);
      send_command(CMD_DELETE, '0, POS_W'(LIST_CAP));
      send_command(CMD_DELETE, '0, POS_W'(LIST_CAP - 1));
      send_command(CMD_APPEND, VAL_MAX, 6'd0);
      send_command(CMD_APPEND, VAL_MIN, 6'd0);
      send_command(CMD_DELETE, '0, 6'd0);
      send_command(CMD_INSERT_FRONT, VAL_MIN, 6'd0);
      send_command(CMD_INSERT_FRONT, '1, 6'd0);
      send_command(CMD_DELETE, '0, 6'd15);
      wait_for_listing();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned         k;
      int unsigned         roll;
      logic [CMD_W-1:0]    cmd;
      logic [DATA_W-1:0]   val;
      logic [POS_W-1:0]    pos;
      for (k = 0; k < n_items; k++) begin
         if (k % 20 == 0) begin
            gap_on   = $urandom_range(0, 2) != 0;
            stall_on = $urandom_range(0, 2) != 0;
         end
         if (k == n_items / 2) wait_for_listing();
         // Deletes grow likelier as the list fills, so its length wanders over the range.
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            cmd = CMD_UNUSED;
         end else if (roll < 5 + 10 + 2 * shadow_count) begin
            cmd = CMD_DELETE;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_FRONT;
         end
         case ($urandom_range(0, 9))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            default: val = $urandom;
         endcase
         if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
            pos = POS_W'($urandom_range(0, shadow_count - 1));
         end else begin
            pos = POS_W'($urandom_range(0, 63));
         end
         send_command(cmd, val, pos);
      end
      wait_for_listing();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_fill_and_overflow();
      test_random_traffic(110);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("PASS positional_list_engine");
      end else begin
         $display("FAIL positional_list_engine");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_ram.sv
hw/rtl/positional_list_engine.sv
test/tb_top.sv
